>>> hw/rtl/bftr_pkg.sv
// Shared constants and types for the bitmap font text renderer.
package bftr_pkg;

    localparam int MAX_GLYPH_ROWS = 32;
    localparam int GLYPH_COUNT    = 256;
    localparam int COORD_BITS     = 16;

    localparam int STORE_DEPTH = 16384;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int BANK_DEPTH  = STORE_DEPTH / 2;
    localparam int BANK_BITS   = ADDR_BITS - 1;
    localparam int ROW_BITS    = $clog2(MAX_GLYPH_ROWS);
    localparam int FONT_BITS   = 6;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_CHAR  = 2'd2;

    localparam logic       CFG_WIDTH  = 1'b0;
    localparam logic       CFG_HEIGHT = 1'b1;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [FONT_BITS-1:0] NARROW_MAX = 6'd8;
    localparam logic [FONT_BITS-1:0] WIDE_MAX   = 6'd16;
    localparam logic [FONT_BITS-1:0] WIDTH_RST  = 6'd8;
    localparam logic [FONT_BITS-1:0] HEIGHT_RST = 6'd16;

    // Font geometry registers.
    typedef struct packed {
        logic [FONT_BITS-1:0] width;
        logic [FONT_BITS-1:0] height;
    } font_cfg_t;

    // Write request into the two byte banks (even and odd addresses).
    typedef struct packed {
        logic [1:0]           we;
        logic [BANK_BITS-1:0] idx;
        logic [7:0]           data;
    } glyph_wr_t;

    // Read request, same index for both banks.
    typedef struct packed {
        logic                 en;
        logic [BANK_BITS-1:0] idx;
    } glyph_rd_t;

endpackage

>>> hw/rtl/bftr_if.sv
// Valid/ready channel interfaces for renderer commands and glyph rows.
interface bftr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [13:0]        font_addr;
    logic [7:0]         font_byte;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [31:0]        color;
    logic [7:0]         ch;

    modport source (output valid, op, font_addr, font_byte, start_x, start_y, color, ch,
                    input ready);
    modport sink (input valid, op, font_addr, font_byte, start_x, start_y, color, ch,
                  output ready);
endinterface

interface bftr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] row_x;
    logic signed [15:0] row_y;
    logic [15:0]        row_bits;
    logic [31:0]        pixel_color;
    logic               last;

    modport source (output valid, row_x, row_y, row_bits, pixel_color, last, input ready);
    modport sink (input valid, row_x, row_y, row_bits, pixel_color, last, output ready);
endinterface

>>> hw/rtl/bftr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module bftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/bftr_engine.sv
// Command sequencer: cursor state, glyph row reads and the result register.
module bftr_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  bftr_pkg::font_cfg_t cfg,
    bftr_in_if.sink             in_ch,
    bftr_out_if.source          out_ch,
    output bftr_pkg::glyph_wr_t wr,
    output bftr_pkg::glyph_rd_t rd,
    input  logic [7:0]          even_data,
    input  logic [7:0]          odd_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    localparam int CB = bftr_pkg::COORD_BITS;
    localparam int AB = bftr_pkg::ADDR_BITS;
    localparam int RB = bftr_pkg::ROW_BITS;
    localparam int FB = bftr_pkg::FONT_BITS;

    logic          state_reg, state_next;
    logic [CB-1:0] cursor_x_reg, cursor_x_next;
    logic [CB-1:0] cursor_y_reg, cursor_y_next;
    logic [CB-1:0] origin_x_reg, origin_x_next;
    logic [31:0]   text_color_reg, text_color_next;

    // Per-character walk.
    logic [AB-1:0] addr_reg, addr_next;
    logic [RB-1:0] row_reg, row_next;
    logic [RB-1:0] rows_m1_reg, rows_m1_next;
    logic [CB-1:0] ry_reg, ry_next;
    logic [CB-1:0] rx_reg, rx_next;
    logic          wide_reg, wide_next;

    // Read stage sideband, aligned with the RAM read data.
    logic          d_valid_reg, d_valid_next;
    logic [CB-1:0] d_y_reg;
    logic          d_last_reg;
    logic          d_sel_reg;
    logic          d_wide_reg;

    // Result register.
    logic          o_valid_reg, o_valid_next;
    logic [CB-1:0] o_x_reg, o_y_reg;
    logic [15:0]   o_bits_reg;
    logic [31:0]   o_color_reg;
    logic          o_last_reg;

    logic          accept;
    logic          issue;
    logic          load_out;
    logic          is_newline;
    logic          draw;
    logic          wide_font;
    logic [AB-1:0] glyph_prod;
    logic [AB-1:0] glyph_base;
    logic [15:0]   row_bits;

    assign in_ch.ready = (state_reg == ST_IDLE) && !d_valid_reg;
    assign accept      = in_ch.valid && in_ch.ready;
    assign load_out    = d_valid_reg && (!o_valid_reg || out_ch.ready);
    assign issue       = (state_reg == ST_RUN) && (!d_valid_reg || load_out);

    // Character decode and glyph base address.
    assign is_newline = (in_ch.ch == bftr_pkg::NEWLINE_CODE);
    assign wide_font  = (cfg.width > bftr_pkg::NARROW_MAX);
    assign draw = (cfg.width <= bftr_pkg::WIDE_MAX)
               && ({1'b0, in_ch.ch} < 9'(bftr_pkg::GLYPH_COUNT))
               && (cfg.height != '0);
    assign glyph_prod = AB'({{(AB-8){1'b0}}, in_ch.ch} * {{(AB-FB){1'b0}}, cfg.height});
    assign glyph_base = wide_font ? {glyph_prod[AB-2:0], 1'b0} : glyph_prod;

    // Glyph store write for load transfers.
    always_comb
    begin
        wr.we   = 2'b00;
        wr.idx  = in_ch.font_addr[AB-1:1];
        wr.data = in_ch.font_byte;
        if (accept && (in_ch.op == bftr_pkg::OP_LOAD))
        begin
            wr.we = in_ch.font_addr[0] ? 2'b10 : 2'b01;
        end
    end

    assign rd.en  = issue;
    assign rd.idx = addr_reg[AB-1:1];

    // Command handling and row sequencing.
    always_comb
    begin
        state_next      = state_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        origin_x_next   = origin_x_reg;
        text_color_next = text_color_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        rows_m1_next    = rows_m1_reg;
        ry_next         = ry_reg;
        rx_next         = rx_reg;
        wide_next       = wide_reg;

        if (accept)
        begin
            case (in_ch.op)
                bftr_pkg::OP_START:
                begin
                    cursor_x_next   = CB'(in_ch.start_x);
                    origin_x_next   = CB'(in_ch.start_x);
                    cursor_y_next   = CB'(in_ch.start_y);
                    text_color_next = in_ch.color;
                end
                bftr_pkg::OP_CHAR:
                begin
                    if (is_newline)
                    begin
                        cursor_x_next = origin_x_reg;
                        cursor_y_next = cursor_y_reg + CB'(cfg.height);
                    end
                    else
                    begin
                        cursor_x_next = cursor_x_reg + CB'(cfg.width);
                        if (draw)
                        begin
                            state_next = ST_RUN;
                            addr_next  = glyph_base;
                            row_next   = '0;
                            rows_m1_next = (cfg.height > FB'(bftr_pkg::MAX_GLYPH_ROWS))
                                         ? RB'(bftr_pkg::MAX_GLYPH_ROWS - 1)
                                         : RB'(cfg.height - 6'd1);
                            ry_next    = cursor_y_reg;
                            rx_next    = cursor_x_reg;
                            wide_next  = wide_font;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (issue)
        begin
            addr_next = addr_reg + (wide_reg ? AB'(2) : AB'(1));
            row_next  = row_reg + RB'(1);
            ry_next   = ry_reg + CB'(1);
            if (row_reg == rows_m1_reg)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    // Read stage occupancy and result register occupancy.
    always_comb
    begin
        d_valid_next = d_valid_reg;
        if (issue)
        begin
            d_valid_next = 1'b1;
        end
        else if (load_out)
        begin
            d_valid_next = 1'b0;
        end

        o_valid_next = o_valid_reg;
        if (load_out)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    // Assemble the pixel mask from the bank outputs.
    assign row_bits = d_wide_reg ? {even_data, odd_data}
                                 : {(d_sel_reg ? odd_data : even_data), 8'h00};

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            origin_x_reg   <= '0;
            text_color_reg <= '0;
            d_valid_reg    <= 1'b0;
            o_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            origin_x_reg   <= origin_x_next;
            text_color_reg <= text_color_next;
            d_valid_reg    <= d_valid_next;
            o_valid_reg    <= o_valid_next;
        end
    end

    // Walk and payload registers.
    always_ff @(posedge clk)
    begin
        addr_reg    <= addr_next;
        row_reg     <= row_next;
        rows_m1_reg <= rows_m1_next;
        ry_reg      <= ry_next;
        rx_reg      <= rx_next;
        wide_reg    <= wide_next;
        if (issue)
        begin
            d_y_reg    <= ry_reg;
            d_last_reg <= (row_reg == rows_m1_reg);
            d_sel_reg  <= addr_reg[0];
            d_wide_reg <= wide_reg;
        end
        if (load_out)
        begin
            o_x_reg     <= rx_reg;
            o_y_reg     <= d_y_reg;
            o_bits_reg  <= row_bits;
            o_color_reg <= text_color_reg;
            o_last_reg  <= d_last_reg;
        end
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.row_x       = o_x_reg[15:0];
    assign out_ch.row_y       = o_y_reg[15:0];
    assign out_ch.row_bits    = o_bits_reg;
    assign out_ch.pixel_color = o_color_reg;
    assign out_ch.last        = o_last_reg;

endmodule

>>> hw/rtl/bitmap_font_text_renderer_unit.sv
// Top level of the bitmap font text renderer: font registers, glyph banks and sequencer.
//
// Load, start and newline transfers do not enter the run state. A printable character reads
// its glyph from the 16 KiB store one row per cycle unless the output stalls, and emits
// min(font_height, 32) rows when the font is at most 16 wide; the store is split
// into even and odd byte banks so that a 16-wide row (two bytes) is still one read.
// The next command is accepted once the last row has left the read stage, while that
// row may still wait in the output register. Glyph bytes that were never loaded read
// back as unknown; there is no clearing pass after reset.
module bitmap_font_text_renderer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data,
    bftr_in_if.sink     in_ch,
    bftr_out_if.source  out_ch
);

    bftr_pkg::font_cfg_t cfg_reg;
    bftr_pkg::glyph_wr_t wr;
    bftr_pkg::glyph_rd_t rd;
    logic [7:0]          even_data;
    logic [7:0]          odd_data;

    // Font geometry registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= bftr_pkg::WIDTH_RST;
            cfg_reg.height <= bftr_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bftr_pkg::CFG_WIDTH:  cfg_reg.width  <= cfg_data;
                bftr_pkg::CFG_HEIGHT: cfg_reg.height <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Even-address glyph bytes.
    bftr_ram #(
        .WIDTH (8),
        .DEPTH (bftr_pkg::BANK_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (wr.we[0]),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.idx),
        .rdata (even_data)
    );

    // Odd-address glyph bytes.
    bftr_ram #(
        .WIDTH (8),
        .DEPTH (bftr_pkg::BANK_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (wr.we[1]),
        .waddr (wr.idx),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.idx),
        .rdata (odd_data)
    );

    bftr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .wr        (wr),
        .rd        (rd),
        .even_data (even_data),
        .odd_data  (odd_data)
    );

endmodule

>>> tb/bftr_row_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap font text renderer: predicts glyph rows and checks the row channel.
module bftr_row_checker
    import bftr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [5:0] cfg_data,
    bftr_in_if         cmd,
    bftr_out_if        rows,
    output int         rows_pending,
    output int         bad_rows
);

    // One glyph row as it leaves the block.
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] bits;
        logic [31:0] color;
        logic        last;
    } glyph_row_t;

    // Shadow copy of the renderer state.
    logic [FONT_BITS-1:0] font_w;
    logic [FONT_BITS-1:0] font_h;
    logic [15:0]          cur_x;
    logic [15:0]          cur_y;
    logic [15:0]          org_x;
    logic [31:0]          ink;
    logic [7:0]           glyph_mem [STORE_DEPTH];

    glyph_row_t rows_due [$];
    glyph_row_t got_row;
    glyph_row_t want_row;
    int         bad_total;

    // Apply one accepted command to the shadow state and queue the rows it draws.
    task automatic render_command();
        int unsigned n_rows;
        int unsigned stride;
        int unsigned base;
        int unsigned r;
        logic [13:0] a;
        glyph_row_t  row;
        case (cmd.op)
            OP_LOAD:
            begin
                glyph_mem[cmd.font_addr] = cmd.font_byte;
            end
            OP_START:
            begin
                cur_x = cmd.start_x;
                org_x = cmd.start_x;
                cur_y = cmd.start_y;
                ink   = cmd.color;
            end
            OP_CHAR:
            begin
                if (cmd.ch == NEWLINE_CODE)
                begin
                    cur_x = org_x;
                    cur_y = cur_y + 16'(font_h);
                end
                else
                begin
                    // Fonts wider than two bytes draw nothing but still advance.
                    if (font_w <= WIDE_MAX)
                    begin
                        stride = (font_w > NARROW_MAX) ? 2 : 1;
                        n_rows = (font_h > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : font_h;
                        base   = cmd.ch * font_h * stride;
                        for (r = 0; r < n_rows; r++)
                        begin
                            a         = 14'(base + r * stride);
                            row.x     = cur_x;
                            row.y     = cur_y + 16'(r);
                            row.bits  = (stride == 2) ? {glyph_mem[a], glyph_mem[a + 14'd1]}
                                                      : {glyph_mem[a], 8'h00};
                            row.color = ink;
                            row.last  = (r + 1 == n_rows);
                            rows_due.push_back(row);
                        end
                    end
                    cur_x = cur_x + 16'(font_w);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Watch the register port and both channels; the command side is handled first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_w    = WIDTH_RST;
            font_h    = HEIGHT_RST;
            cur_x     = '0;
            cur_y     = '0;
            org_x     = '0;
            ink       = '0;
            bad_total = 0;
            rows_due.delete();
            rows_pending <= 0;
            bad_rows     <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    font_w = cfg_data;
                else
                    font_h = cfg_data;
            end

            if (cmd.valid && cmd.ready)
                render_command();

            if (rows.valid && rows.ready)
            begin
                got_row = {rows.row_x, rows.row_y, rows.row_bits, rows.pixel_color, rows.last};
                if (rows_due.size() == 0)
                begin
                    $display("%0t: row transfer with nothing expected: got x=%0d y=%0d bits=%h color=%h last=%b",
                             $time, $signed(got_row.x), $signed(got_row.y), got_row.bits,
                             got_row.color, got_row.last);
                    bad_total++;
                end
                else
                begin
                    want_row = rows_due.pop_front();
                    if (got_row !== want_row)
                    begin
                        $display("%0t: row mismatch: expected x=%0d y=%0d bits=%h color=%h last=%b",
                                 $time, $signed(want_row.x), $signed(want_row.y), want_row.bits,
                                 want_row.color, want_row.last);
                        $display("%0t:               got x=%0d y=%0d bits=%h color=%h last=%b",
                                 $time, $signed(got_row.x), $signed(got_row.y), got_row.bits,
                                 got_row.color, got_row.last);
                        bad_total++;
                    end
                end
            end

            rows_pending <= rows_due.size();
            bad_rows     <= bad_total;
        end
    end

endmodule

>>> tb/tb_bitmap_font_text_renderer_unit.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the bitmap font text renderer, checked by bftr_row_checker.
module tb_bitmap_font_text_renderer_unit;
    import bftr_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 110;
    localparam int         DRAIN_CYCLES = 40;

    // One command as it is placed on the command channel.
    typedef struct packed {
        logic [1:0]  op;
        logic [13:0] font_addr;
        logic [7:0]  font_byte;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [31:0] color;
        logic [7:0]  ch;
    } command_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [5:0] cfg_data;
    int         rows_pending;
    int         bad_rows;

    bftr_in_if  cmd_if ();
    bftr_out_if row_if ();

    // Geometry the block currently holds, and which glyph bytes have been loaded.
    logic [FONT_BITS-1:0] font_w;
    logic [FONT_BITS-1:0] font_h;
    bit                   loaded [STORE_DEPTH];
    bit                   tx_steady;
    bit                   rx_steady;
    int                   random_items;

    bitmap_font_text_renderer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (cmd_if),
        .out_ch   (row_if)
    );

    bftr_row_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd_if),
        .rows        (row_if),
        .rows_pending(rows_pending),
        .bad_rows    (bad_rows)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog for a hung run.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Row sink with a random stall before each transfer unless rx_steady is set.
    initial
    begin : row_sink
        int stall;
        row_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                row_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            row_if.ready <= 1'b1;
            @(posedge clk);
            while (!row_if.valid) @(posedge clk);
        end
    end

    function automatic command_t random_command();
        return {$urandom(), $urandom(), $urandom()};
    endfunction

    // Present one command after a random gap (none while tx_steady is set) and hold it until the transfer.
    task automatic issue(input command_t c);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.op        <= c.op;
        cmd_if.font_addr <= c.font_addr;
        cmd_if.font_byte <= c.font_byte;
        cmd_if.start_x   <= c.start_x;
        cmd_if.start_y   <= c.start_y;
        cmd_if.color     <= c.color;
        cmd_if.ch        <= c.ch;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        random_items++;
    endtask

    task automatic load_byte(input logic [13:0] addr, input logic [7:0] data);
        command_t c;
        c           = random_command();
        c.op        = OP_LOAD;
        c.font_addr = addr;
        c.font_byte = data;
        loaded[addr] = 1'b1;
        issue(c);
    endtask

    task automatic start_text(input logic [15:0] x, input logic [15:0] y,
                              input logic [31:0] color);
        command_t c;
        c         = random_command();
        c.op      = OP_START;
        c.start_x = x;
        c.start_y = y;
        c.color   = color;
        issue(c);
    endtask

    // Send a character, first loading any glyph byte it reads that is still unwritten.
    task automatic put_char(input logic [7:0] code);
        int unsigned n_rows;
        int unsigned stride;
        int unsigned base;
        int unsigned r;
        int unsigned a;
        command_t    c;
        if (code != NEWLINE_CODE && font_w <= WIDE_MAX)
        begin
            stride = (font_w > NARROW_MAX) ? 2 : 1;
            n_rows = (font_h > MAX_GLYPH_ROWS) ? MAX_GLYPH_ROWS : font_h;
            base   = code * font_h * stride;
            for (r = 0; r < n_rows * stride; r++)
            begin
                a = (base + r) % STORE_DEPTH;
                if (!loaded[a])
                    load_byte(14'(a), 8'($urandom()));
            end
        end
        c    = random_command();
        c.op = OP_CHAR;
        c.ch = code;
        issue(c);
    endtask

    task automatic put_unused();
        command_t c;
        c    = random_command();
        c.op = OP_UNUSED;
        issue(c);
    endtask

    // Wait until every expected row has left, then let the block go quiet.
    // The pending count is updated at the clock edge, so the task waits on the clock before it looks.
    task automatic settle();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both geometry registers; only called while the block is idle.
    task automatic set_font(input logic [5:0] w, input logic [5:0] h);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        font_w = w;
        font_h = h;
    endtask

    // Main sequence: reset, directed corners, then random text phases.
    // Every command transfer counts toward the item budget, glyph loads included.
    initial
    begin : stimulus
        logic [7:0] pool [4];
        logic [5:0] w;
        logic [5:0] h;
        int         sel;
        int         k;
        int         n_chars;

        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_WIDTH;
        cfg_data         <= '0;
        cmd_if.valid     <= 1'b0;
        cmd_if.op        <= OP_LOAD;
        cmd_if.font_addr <= '0;
        cmd_if.font_byte <= '0;
        cmd_if.start_x   <= '0;
        cmd_if.start_y   <= '0;
        cmd_if.color     <= '0;
        cmd_if.ch        <= '0;
        font_w       = WIDTH_RST;
        font_h       = HEIGHT_RST;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        random_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry, address extremes, code zero and coordinates that wrap.
        load_byte(14'h3FFF, 8'hFF);
        load_byte(14'h0000, 8'h00);
        start_text(16'h8000, 16'h7FFF, 32'hFFFF_FFFF);
        put_char(8'd0);
        put_char(8'd255);
        put_char(NEWLINE_CODE);
        put_unused();

        // Sixteen-wide glyphs and a cursor that wraps past the right edge.
        set_font(6'd16, 6'd2);
        start_text(16'h7FFF, 16'h8000, 32'h0000_0000);
        put_char(8'd128);
        put_char(8'd127);

        // The narrowest wide font.
        set_font(6'd9, 6'd1);
        put_char(8'd200);

        // Zero width draws but does not advance.
        set_font(6'd0, 6'd3);
        put_char(8'd65);
        put_char(8'd65);

        // Too wide to draw, still advancing.
        set_font(6'd17, 6'd2);
        put_char(8'd66);
        put_char(NEWLINE_CODE);

        // Zero height draws no rows.
        set_font(6'd8, 6'd0);
        put_char(8'd67);
        put_char(NEWLINE_CODE);

        // Tall font: rows stop at the maximum, stride keeps the full height.
        set_font(6'd8, 6'd40);
        put_char(8'd2);

        // Register maxima.
        set_font(6'd63, 6'd63);
        put_char(8'd3);
        put_char(NEWLINE_CODE);

        // Random phases: each picks a geometry, idling style and a small alphabet.
        while (random_items < RANDOM_ITEMS)
        begin
            sel = $urandom_range(0, 3);
            case (sel)
                0:       w = 6'($urandom_range(9, 16));
                1:       w = 6'($urandom_range(17, 63));
                default: w = 6'($urandom_range(0, 8));
            endcase
            sel = $urandom_range(0, 15);
            case (sel)
                0:       h = 6'd0;
                1:       h = 6'd32;
                2:       h = 6'($urandom_range(33, 63));
                default: h = 6'($urandom_range(1, 8));
            endcase
            set_font(w, h);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            for (k = 0; k < 4; k++)
                pool[k] = 8'($urandom());

            start_text(16'($urandom()), 16'($urandom()), $urandom());
            n_chars = $urandom_range(8, 16);
            for (k = 0; k < n_chars && random_items < RANDOM_ITEMS; k++)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 12)
                    put_char(pool[sel % 4]);
                else if (sel < 14)
                    put_char(NEWLINE_CODE);
                else if (sel < 16)
                    start_text(16'($urandom()), 16'($urandom()), $urandom());
                else if (sel < 18)
                    load_byte(14'($urandom()), 8'($urandom()));
                else if (sel == 18)
                    put_char(8'($urandom()));
                else
                    put_unused();
            end
        end

        settle();
        if (bad_rows == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/bftr_pkg.sv
hw/rtl/bftr_if.sv
hw/rtl/bftr_ram.sv
hw/rtl/bftr_engine.sv
hw/rtl/bitmap_font_text_renderer_unit.sv
tb/bftr_row_checker.sv
tb/tb_bitmap_font_text_renderer_unit.sv
